[rtl/gbc_pkg.sv]
// gbc_pkg: shared constants, s-box table and round function for the gost 64-bit cipher
// no dependencies; used by gbc_keys, gbc_round and gost_block_cipher_64
`timescale 1ns / 1ps

package gbc_pkg;

	localparam int unsigned ROUNDS    = 32;
	localparam int unsigned NUM_KEYS  = 8;
	localparam int unsigned KEY_IDX_W = 3;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned HALF_W    = 32;
	localparam int unsigned RND_W     = 5;
	localparam int unsigned ROT       = 11;

	typedef logic [HALF_W-1:0] half_t;
	typedef logic [NUM_KEYS-1:0][HALF_W-1:0] key_bank_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;
	typedef logic [3:0] nib_t;

	// row 0 serves the most significant nibble
	localparam nib_t SBOX [8][16] = '{
		'{4'h9, 4'h6, 4'h3, 4'h2, 4'h8, 4'hB, 4'h1, 4'h7,
		  4'hA, 4'h4, 4'hE, 4'hF, 4'hC, 4'h0, 4'hD, 4'h5},
		'{4'h3, 4'h7, 4'hE, 4'h9, 4'h8, 4'hA, 4'hF, 4'h0,
		  4'h5, 4'h2, 4'h6, 4'hC, 4'hB, 4'h4, 4'hD, 4'h1},
		'{4'hE, 4'h4, 4'h6, 4'h2, 4'hB, 4'h3, 4'hD, 4'h8,
		  4'hC, 4'hF, 4'h5, 4'hA, 4'h0, 4'h7, 4'h1, 4'h9},
		'{4'hE, 4'h7, 4'hA, 4'hC, 4'hD, 4'h1, 4'h3, 4'h9,
		  4'h0, 4'h2, 4'hB, 4'h4, 4'hF, 4'h8, 4'h5, 4'h6},
		'{4'hB, 4'h5, 4'h1, 4'h9, 4'h8, 4'hD, 4'hF, 4'h0,
		  4'hE, 4'h4, 4'h2, 4'h3, 4'hC, 4'h7, 4'hA, 4'h6},
		'{4'h3, 4'hA, 4'hD, 4'hC, 4'h1, 4'h2, 4'h0, 4'hB,
		  4'h7, 4'h5, 4'h9, 4'h4, 4'h8, 4'hF, 4'hE, 4'h6},
		'{4'h1, 4'hD, 4'h2, 4'h9, 4'h7, 4'hA, 4'h6, 4'h0,
		  4'h8, 4'hC, 4'h4, 4'h5, 4'hF, 4'h3, 4'hB, 4'hE},
		'{4'hB, 4'hA, 4'hF, 4'h5, 4'h0, 4'hC, 4'hE, 4'h8,
		  4'h6, 4'h2, 4'h3, 4'h9, 4'h1, 4'h7, 4'hD, 4'h4}
	};

	// key word for a round: 0..7 three times then 7..0; decrypt runs it backwards
	function automatic key_idx_t key_sel(input logic [RND_W-1:0] rnd, input logic dec);
		logic [RND_W-1:0] r;
		begin
			r = dec ? (RND_W'(ROUNDS - 1) - rnd) : rnd;
			key_sel = (r < RND_W'(24)) ? r[KEY_IDX_W-1:0] : ~r[KEY_IDX_W-1:0];
		end
	endfunction

	// add key, substitute nibbles, rotate left
	function automatic half_t round_f(input half_t a, input half_t k);
		half_t sum;
		half_t sub;
		begin
			sum = a + k;
			for (int i = 0; i < 8; i++) begin
				sub[31-4*i -: 4] = SBOX[i][sum[31-4*i -: 4]];
			end
			round_f = {sub[HALF_W-ROT-1:0], sub[HALF_W-1:HALF_W-ROT]};
		end
	endfunction

endpackage

[rtl/gost_block_cipher_64.sv]
// gost_block_cipher_64: 32-round gost 28147-89 block cipher, one round per pipeline stage
// depends on gbc_pkg, gbc_keys, gbc_round
`timescale 1ns / 1ps

// channel   direction  signals                                   width
// blk       in         blk_valid, blk_ready, block_in, decrypt   64 + 1
// res       out        res_valid, res_ready, block_out           64
// cfg       in         cfg_valid, cfg_ready, cfg_index, cfg_data 8 + 32
//
// one item enters per cycle unless a stalled result has backed up into the first stage
// the per-stage add, s-box, rotate and xor set the stage depth
// the last stage register drives the result channel directly
// a stalled result holds its own stage and every full stage behind it; empty stages behind it keep filling
// reset clears all stage valid bits and the key words; cfg_ready is always high

module gost_block_cipher_64 (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          blk_valid,
	output logic                          blk_ready,
	input  logic [63:0]                   block_in,
	input  logic                          decrypt,
	// result items
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [63:0]                   block_out,
	// key word writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	localparam int unsigned N = gbc_pkg::ROUNDS;

	gbc_pkg::key_bank_t keys;

	// stage boundaries: index i feeds round i, index N is the result
	logic           v_c   [N+1];
	logic           rdy_c [N+1];
	gbc_pkg::half_t a_c   [N+1];
	gbc_pkg::half_t b_c   [N+1];
	logic           dec_c [N+1];

	gbc_keys u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.keys      (keys)
	);

	// upper half is b, lower half is a
	assign v_c[0]    = blk_valid;
	assign a_c[0]    = block_in[31:0];
	assign b_c[0]    = block_in[63:32];
	assign dec_c[0]  = decrypt;
	assign blk_ready = rdy_c[0];

	for (genvar i = 0; i < N; i++) begin : g_rnd
		gbc_round #(
			.ROUND (i)
		) u_rnd (
			.clk      (clk),
			.arst_n   (arst_n),
			.keys     (keys),
			.up_valid (v_c[i]),
			.up_ready (rdy_c[i]),
			.up_a     (a_c[i]),
			.up_b     (b_c[i]),
			.up_dec   (dec_c[i]),
			.dn_valid (v_c[i+1]),
			.dn_ready (rdy_c[i+1]),
			.dn_a     (a_c[i+1]),
			.dn_b     (b_c[i+1]),
			.dn_dec   (dec_c[i+1])
		);
	end

	// direction flag is not needed past the last round
	assign rdy_c[N]  = res_ready;
	assign res_valid = v_c[N] && (dec_c[N] || !dec_c[N]);
	assign block_out = {b_c[N], a_c[N]};

endmodule

[rtl/gbc_keys.sv]
// gbc_keys: key word register bank written through the configuration channel
// depends on gbc_pkg
`timescale 1ns / 1ps

module gbc_keys (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  gbc_pkg::half_t                   cfg_data,
	output gbc_pkg::key_bank_t               keys
);

	gbc_pkg::key_bank_t keys_q;
	logic               hit;

	assign cfg_ready = 1'b1;
	// indexes past the bank are dropped
	assign hit = cfg_index < gbc_pkg::CFG_IDX_W'(gbc_pkg::NUM_KEYS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
		end else if (cfg_valid && hit) begin
			keys_q[cfg_index[gbc_pkg::KEY_IDX_W-1:0]] <= cfg_data;
		end
	end

	assign keys = keys_q;

endmodule

[rtl/gbc_round.sv]
// gbc_round: one feistel round followed by its pipeline register and handshake
// depends on gbc_pkg
`timescale 1ns / 1ps

module gbc_round #(
	parameter int unsigned ROUND = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gbc_pkg::key_bank_t keys,
	input  logic               up_valid,
	output logic               up_ready,
	input  gbc_pkg::half_t     up_a,
	input  gbc_pkg::half_t     up_b,
	input  logic               up_dec,
	output logic               dn_valid,
	input  logic               dn_ready,
	output gbc_pkg::half_t     dn_a,
	output gbc_pkg::half_t     dn_b,
	output logic               dn_dec
);

	localparam logic LAST = (ROUND == gbc_pkg::ROUNDS - 1);

	logic              valid_s1;
	gbc_pkg::half_t    a_s1;
	gbc_pkg::half_t    b_s1;
	logic              dec_s1;
	gbc_pkg::key_idx_t kidx;
	gbc_pkg::half_t    t;
	gbc_pkg::half_t    a_nxt;
	gbc_pkg::half_t    b_nxt;

	assign kidx = gbc_pkg::key_sel(gbc_pkg::RND_W'(ROUND), up_dec);
	assign t    = up_b ^ gbc_pkg::round_f(up_a, keys[kidx]);

	// final round keeps the halves in place
	always_comb begin
		if (LAST) begin
			a_nxt = up_a;
			b_nxt = t;
		end else begin
			a_nxt = t;
			b_nxt = up_a;
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			a_s1   <= a_nxt;
			b_s1   <= b_nxt;
			dec_s1 <= up_dec;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_a     = a_s1;
	assign dn_b     = b_s1;
	assign dn_dec   = dec_s1;

endmodule

[rtl/gbc_checker.sv]
// gbc_checker: port-level checks for gost_block_cipher_64, bound to the top level
// depends on gbc_pkg and gost_block_cipher_64 port names
`timescale 1ns / 1ps

module gbc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          blk_valid,
	input logic                          blk_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [63:0]                   block_out,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [gbc_pkg::CFG_IDX_W-1:0] cfg_index
);

	// items inside the pipeline
	logic [5:0] cnt_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = blk_valid && blk_ready;
	assign out_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 6'(in_acc) - 6'(out_acc);
		end
	end

	// a held result keeps its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(block_out))
		else $error("result dropped or changed while stalled");

	// an empty or draining output lets the whole pipe accept
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid || res_ready) |-> blk_ready)
		else $error("input stalled with output free");

	// no result without an item inside
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cnt_q != 6'd0)
		else $error("result with no item in flight");

	// occupancy bounded by the round stages
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'(gbc_pkg::ROUNDS))
		else $error("more items in flight than stages");

	// key writes never back-pressure
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("key write stalled at index %0d", cfg_index);

endmodule

bind gost_block_cipher_64 gbc_checker u_gbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.blk_valid (blk_valid),
	.blk_ready (blk_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.block_out (block_out),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index)
);

[tb/gost_block_cipher_64_tb.sv]
// gost_block_cipher_64_tb: self-checking bench for the 32-round gost 64-bit cipher
// predicts every block with its own feistel model and the key words it has written
// depends on gbc_pkg and gost_block_cipher_64
`timescale 1ns / 1ps

module gost_block_cipher_64_tb;

	localparam int unsigned CLK_HIGH      = 2;
	localparam int unsigned CLK_LOW       = 2;
	localparam int unsigned RESET_CYCLES  = 3;
	// pipeline depth plus some margin, waited out before key writes and at the end
	localparam int unsigned SETTLE_CYCLES = gbc_pkg::ROUNDS + 8;
	localparam int unsigned PHASE_ITEMS   = 250;
	// set well above the slowest legal run, this leaves a wide margin
	localparam int unsigned CYCLE_LIMIT   = 200000;

	// key word register indexes; anything from KEY_REG_END up must be ignored
	typedef enum logic [gbc_pkg::CFG_IDX_W-1:0] {
		KEY_WORD_0, KEY_WORD_1, KEY_WORD_2, KEY_WORD_3,
		KEY_WORD_4, KEY_WORD_5, KEY_WORD_6, KEY_WORD_7,
		KEY_REG_END
	} key_reg_t;
	localparam logic [gbc_pkg::CFG_IDX_W-1:0] KEY_REG_TOP = '1;

	// substitution boxes, one 64-bit row per box, entry v at bits [4v+3:4v]
	// box 0 serves the most significant nibble
	localparam logic [7:0][63:0] SBOX_ROWS = {
		64'h4D71932_68EC05FAB,
		64'hEB3F54C8_06A792D1,
		64'h6EF84957_B021CDA3,
		64'h6A7C324E_0FD8915B,
		64'h658F4B20_931DCA7E,
		64'h9170A5FC_8D3B264E,
		64'h1D4BC625_0FA89E73,
		64'h5D0CFE4A_71B82369
	};

	logic                            clk;
	logic                            arst_n;
	logic                            blk_valid;
	logic                            blk_ready;
	logic [63:0]                     block_in;
	logic                            decrypt;
	logic                            res_valid;
	logic                            res_ready;
	logic [63:0]                     block_out;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [gbc_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [31:0]                     cfg_data;

	// key words as the block should hold them
	gbc_pkg::half_t key_words [gbc_pkg::NUM_KEYS];
	// blocks still owed by the cipher, oldest first
	logic [63:0]    pending_blocks [$];
	logic [63:0]    owed_block;
	int unsigned    mismatch_count = 0;
	int unsigned    cycle_count = 0;
	// idle odds in percent, changed per phase
	int unsigned    send_idle_pct;
	int unsigned    recv_stall_pct;

	gost_block_cipher_64 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.block_in  (block_in),
		.decrypt   (decrypt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.block_out (block_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#CLK_LOW;
		clk = 1'b1;
		#CLK_HIGH;
	end

	// ---------------------------------------------------------------
	// cipher prediction
	// ---------------------------------------------------------------

	// one round function: key add mod 2^32, nibble substitution, rotate left 11
	function automatic gbc_pkg::half_t gost_mix(input gbc_pkg::half_t a,
			input gbc_pkg::half_t k);
		gbc_pkg::half_t sum;
		gbc_pkg::half_t sub;
		logic [3:0]     nib;
		sum = a + k;
		for (int i = 0; i < 8; i++) begin
			nib = sum[31-4*i -: 4];
			sub[31-4*i -: 4] = SBOX_ROWS[i][{nib, 2'b00} +: 4];
		end
		return {sub[20:0], sub[31:21]};
	endfunction

	// full 32-round cipher on {B, A}; decrypt walks the key schedule backwards
	function automatic logic [63:0] gost_cipher(input logic [63:0] blk, input logic dec);
		gbc_pkg::half_t a;
		gbc_pkg::half_t b;
		gbc_pkg::half_t t;
		int unsigned    sched;
		int unsigned    kidx;
		b = blk[63:32];
		a = blk[31:0];
		for (int r = 0; r < gbc_pkg::ROUNDS; r++) begin
			sched = dec ? (gbc_pkg::ROUNDS - 1 - r) : r;
			// 0..7 three times, then 7..0
			kidx = (sched < 24) ? (sched % 8) : (7 - sched % 8);
			t = b ^ gost_mix(a, key_words[kidx]);
			// last round keeps the halves in place
			if (r == gbc_pkg::ROUNDS - 1) begin
				b = t;
			end else begin
				b = a;
				a = t;
			end
		end
		return {b, a};
	endfunction

	// ---------------------------------------------------------------
	// result checking, sampled at the rising edge
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_blocks.size() == 0) begin
				$error("block_out: expected none, actual %h", block_out);
				mismatch_count++;
			end else begin
				owed_block = pending_blocks.pop_front();
				if (block_out !== owed_block) begin
					$error("block_out: expected %h, actual %h", owed_block, block_out);
					mismatch_count++;
				end
			end
		end
	end

	// receiver back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		res_ready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// offer one block, hold it until taken, then record what it must turn into
	task automatic send_block(input logic [63:0] blk, input logic dec);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			blk_valid = 1'b0;
			@(negedge clk);
		end
		blk_valid = 1'b1;
		block_in  = blk;
		decrypt   = dec;
		do @(posedge clk); while (!blk_ready);
		pending_blocks.push_back(gost_cipher(blk, dec));
	endtask

	// stop offering, let every owed block come out, then let the pipe settle
	task automatic drain_pipe();
		@(negedge clk);
		blk_valid = 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one key word write; only called with the pipe drained
	task automatic write_key(input logic [gbc_pkg::CFG_IDX_W-1:0] idx,
			input gbc_pkg::half_t value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < KEY_REG_END) key_words[idx[gbc_pkg::KEY_IDX_W-1:0]] = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all_keys(input gbc_pkg::half_t value);
		for (int i = 0; i < gbc_pkg::NUM_KEYS; i++) begin
			write_key(gbc_pkg::CFG_IDX_W'(KEY_WORD_0 + i), value);
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// keys straight out of reset are all zero
	task automatic test_reset_keys();
		send_block(64'h0, 1'b0);
		send_block(64'h0, 1'b1);
		send_block('1, 1'b0);
		send_block('1, 1'b1);
		drain_pipe();
	endtask

	// all-ones keys, then a distinct key per word, with extreme blocks and a round trip
	task automatic test_key_extremes();
		logic [63:0] cipher;
		write_all_keys('1);
		send_block(64'h0, 1'b0);
		send_block('1, 1'b0);
		send_block(64'h8000_0000_0000_0000, 1'b1);
		send_block(64'h0000_0000_0000_0001, 1'b1);
		drain_pipe();
		write_key(KEY_WORD_0, 32'h0000_0000);
		write_key(KEY_WORD_1, 32'hFFFF_FFFF);
		write_key(KEY_WORD_2, 32'h8000_0000);
		write_key(KEY_WORD_3, 32'h0000_0001);
		write_key(KEY_WORD_4, 32'hAAAA_AAAA);
		write_key(KEY_WORD_5, 32'h5555_5555);
		write_key(KEY_WORD_6, 32'h0123_4567);
		write_key(KEY_WORD_7, 32'hFEDC_BA98);
		send_block(64'hAAAA_AAAA_5555_5555, 1'b0);
		send_block(64'h5555_5555_AAAA_AAAA, 1'b1);
		send_block(64'hFFFF_FFFF_0000_0000, 1'b0);
		send_block(64'h0000_0000_FFFF_FFFF, 1'b1);
		// encrypt then decrypt the ciphertext: must give the plaintext back
		cipher = gost_cipher(64'h0123_4567_89AB_CDEF, 1'b0);
		send_block(64'h0123_4567_89AB_CDEF, 1'b0);
		send_block(cipher, 1'b1);
		drain_pipe();
	endtask

	// writes past the last key word must leave every key alone
	task automatic test_stray_index();
		write_key(KEY_REG_END, 32'hDEAD_BEEF);
		write_key(KEY_REG_TOP, 32'h1234_5678);
		send_block(64'hFEDC_BA98_7654_3210, 1'b0);
		send_block(64'hFEDC_BA98_7654_3210, 1'b1);
		drain_pipe();
	endtask

	// fresh random key set (some words at extremes), then a stream of random blocks
	task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned count);
		logic [63:0]    blk;
		logic [63:0]    cipher;
		logic           dec;
		int unsigned    sent;
		gbc_pkg::half_t kval;
		drain_pipe();
		for (int i = 0; i < gbc_pkg::NUM_KEYS; i++) begin
			case ($urandom_range(0, 9))
				0:       kval = '0;
				1:       kval = '1;
				default: kval = $urandom;
			endcase
			write_key(gbc_pkg::CFG_IDX_W'(KEY_WORD_0 + i), kval);
		end
		// one stray write after each key set
		write_key(gbc_pkg::CFG_IDX_W'($urandom_range(KEY_REG_END, KEY_REG_TOP)), $urandom);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < count) begin
			blk = {$urandom, $urandom};
			dec = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: begin
					case ($urandom_range(0, 3))
						0: blk = '0;
						1: blk = '1;
						2: blk = 64'h1 << $urandom_range(0, 63);
						default: blk = ~(64'h1 << $urandom_range(0, 63));
					endcase
					send_block(blk, dec);
					sent++;
				end
				1, 2: begin
					// round trip through the opposite direction
					cipher = gost_cipher(blk, dec);
					send_block(blk, dec);
					send_block(cipher, ~dec);
					sent += 2;
				end
				default: begin
					send_block(blk, dec);
					sent++;
				end
			endcase
		end
		drain_pipe();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n         = 1'b0;
		blk_valid      = 1'b0;
		block_in       = '0;
		decrypt        = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < gbc_pkg::NUM_KEYS; i++) key_words[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_keys();
		test_key_extremes();
		test_stray_index();
		// no idling, sender idle, receiver stalling, both
		test_random_phase(0, 0, PHASE_ITEMS);
		test_random_phase(73, 0, PHASE_ITEMS);
		test_random_phase(0, 73, PHASE_ITEMS);
		test_random_phase(31, 31, PHASE_ITEMS);

		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
